// ----- hdl/mrsc_pkg.sv -----
// package: widths, codes, payload types and step functions for the merge speed cap
package mrsc_pkg;

  localparam int SPEED_WIDTH = 16;
  localparam int DIST_WIDTH  = 16;
  localparam int LIMIT_WIDTH = 24;
  localparam int Q_FRAC      = 16;
  localparam int P_SHIFT     = 8;

  localparam int QUO_WIDTH  = DIST_WIDTH + Q_FRAC;
  localparam int ROOT_WIDTH = (QUO_WIDTH + 1) / 2;
  localparam int RAD_WIDTH  = 2 * ROOT_WIDTH;
  localparam int SREM_WIDTH = ROOT_WIDTH + 2;
  localparam int PROD_WIDTH = SPEED_WIDTH + ROOT_WIDTH;
  localparam int CMP_WIDTH  = (PROD_WIDTH > LIMIT_WIDTH) ? PROD_WIDTH : LIMIT_WIDTH;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_MAX = {LIMIT_WIDTH{1'b1}};

  localparam logic [2:0] OP_MERGE_READY = 3'd0;
  localparam logic [2:0] OP_WAIT        = 3'd1;
  localparam logic [2:0] OP_HOLD        = 3'd2;

  typedef struct packed {
    logic                   received;
    logic                   fresh;
    logic                   active;
    logic                   in_zone;
    logic [2:0]             op;
    logic [SPEED_WIDTH-1:0] ego_speed;
    logic [DIST_WIDTH-1:0]  available_distance;
    logic [DIST_WIDTH-1:0]  stop_distance;
  } frame_t;

  typedef struct packed {
    logic                   limit_valid;
    logic [LIMIT_WIDTH-1:0] speed_limit;
    logic                   merge_authorized;
  } cap_t;

  // per-item control that travels down the pipeline
  typedef struct packed {
    logic                   calc;
    logic                   lim;
    logic                   auth;
    logic [SPEED_WIDTH-1:0] speed;
  } tag_t;

  typedef struct packed {
    logic [DIST_WIDTH-1:0] rem;
    logic [QUO_WIDTH-1:0]  num;
  } div_res_t;

  typedef struct packed {
    logic [SREM_WIDTH-1:0] rem;
    logic [ROOT_WIDTH-1:0] root;
  } sqrt_res_t;

  // one restoring division step: next dividend bit in, one quotient bit out
  function automatic div_res_t div_step(input logic [DIST_WIDTH-1:0] rem,
                                        input logic [QUO_WIDTH-1:0]  num,
                                        input logic [DIST_WIDTH-1:0] dvs);
    logic [DIST_WIDTH:0] sh;
    logic [DIST_WIDTH:0] diff;
    div_res_t            res;
    sh   = {rem, num[QUO_WIDTH-1]};
    diff = sh - {1'b0, dvs};
    if (sh >= {1'b0, dvs}) begin
      res.rem = diff[DIST_WIDTH-1:0];
      res.num = {num[QUO_WIDTH-2:0], 1'b1};
    end else begin
      res.rem = sh[DIST_WIDTH-1:0];
      res.num = {num[QUO_WIDTH-2:0], 1'b0};
    end
    return res;
  endfunction

  // one digit-by-digit square root step on the next two radicand bits
  function automatic sqrt_res_t sqrt_step(input logic [SREM_WIDTH-1:0] rem,
                                          input logic [ROOT_WIDTH-1:0] root,
                                          input logic [1:0]            pair);
    logic [SREM_WIDTH-1:0] sh;
    logic [SREM_WIDTH-1:0] trial;
    sqrt_res_t             res;
    sh    = {rem[ROOT_WIDTH-1:0], pair};
    trial = {root, 2'b01};
    if (sh >= trial) begin
      res.rem  = sh - trial;
      res.root = {root[ROOT_WIDTH-2:0], 1'b1};
    end else begin
      res.rem  = sh;
      res.root = {root[ROOT_WIDTH-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

// ----- hdl/merge_response_speed_cap.sv -----
// top level: pipelined speed cap from one merge-response frame
//
// frame channel: frame_valid / frame_stall carry one frame_t per transfer.
// cap channel: cap_valid / cap_stall carry one cap_t result per frame, in order.
// every frame gives exactly one result; no state is kept between frames.
// pipeline: DIST_WIDTH + 16 divider stages, one root stage per root bit,
// a capture stage, a multiply stage and the output register.
// throughput: one frame per cycle while cap_stall holds no result, set by
// the one-step-per-stage divider and square root pipelines.
// a wait frame with nonzero distances computes speed * floor(sqrt((avail << 16) / stop)) >> 8,
// saturated to 24 bits; hold or a zero distance gives a zero cap, merge ready authorizes.
// the whole pipeline advances together; while the output register holds a
// result under cap_stall, frame_stall is high and no stage moves.
// reset (rst, synchronous) clears all stage valid bits and cap_valid.
module merge_response_speed_cap (
  input  logic            clk,
  input  logic            rst,
  input  logic            frame_valid,
  output logic            frame_stall,
  input  mrsc_pkg::frame_t frame,
  output logic            cap_valid,
  input  logic            cap_stall,
  output mrsc_pkg::cap_t  cap
);
  import mrsc_pkg::*;

  localparam int N_DIV = QUO_WIDTH;
  localparam int N_SQ  = ROOT_WIDTH;

  logic adv;

  logic                  dv   [0:N_DIV];
  tag_t                  dtag [0:N_DIV];
  logic [DIST_WIDTH-1:0] drem [0:N_DIV];
  logic [QUO_WIDTH-1:0]  dnum [0:N_DIV];
  logic [DIST_WIDTH-1:0] ddvs [0:N_DIV];

  logic                  sv    [0:N_SQ-1];
  tag_t                  stag  [0:N_SQ-1];
  logic [SREM_WIDTH-1:0] srem  [0:N_SQ-1];
  logic [ROOT_WIDTH-1:0] sroot [0:N_SQ-1];
  logic [RAD_WIDTH-1:0]  srad  [0:N_SQ-1];

  logic                  mv;
  tag_t                  mtag;
  logic [PROD_WIDTH-1:0] mprod;

  logic                  usable;
  tag_t                  tag_in;
  logic [PROD_WIDTH-1:0] shifted;
  logic [CMP_WIDTH-1:0]  shifted_ext;
  logic [LIMIT_WIDTH-1:0] sat;
  cap_t                  cap_next;

  assign adv         = !(cap_valid && cap_stall);
  assign frame_stall = !adv;

  // decode
  always_comb begin
    usable        = frame.received && frame.fresh && frame.active && frame.in_zone;
    tag_in.calc   = usable && (frame.op == OP_WAIT) &&
                    (frame.available_distance != '0) && (frame.stop_distance != '0);
    tag_in.lim    = usable && ((frame.op == OP_HOLD) || tag_in.calc);
    tag_in.auth   = usable && (frame.op == OP_MERGE_READY);
    tag_in.speed  = frame.ego_speed;
  end

  // capture stage
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dtag[0] <= tag_in;
      drem[0] <= '0;
      dnum[0] <= {frame.available_distance, {Q_FRAC{1'b0}}};
      ddvs[0] <= frame.stop_distance;
    end
  end

  // divider stages
  for (genvar k = 1; k <= N_DIV; k++) begin : g_div
    div_res_t step;
    assign step = div_step(drem[k-1], dnum[k-1], ddvs[k-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (adv) begin
        dv[k] <= dv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dtag[k] <= dtag[k-1];
        drem[k] <= step.rem;
        dnum[k] <= step.num;
        ddvs[k] <= ddvs[k-1];
      end
    end
  end

  // square root stages
  for (genvar j = 0; j < N_SQ; j++) begin : g_sqrt
    logic                  v_src;
    tag_t                  tag_src;
    logic [SREM_WIDTH-1:0] rem_src;
    logic [ROOT_WIDTH-1:0] root_src;
    logic [RAD_WIDTH-1:0]  rad_src;
    sqrt_res_t             step;

    if (j == 0) begin : g_first
      assign v_src    = dv[N_DIV];
      assign tag_src  = dtag[N_DIV];
      assign rem_src  = '0;
      assign root_src = '0;
      assign rad_src  = RAD_WIDTH'(dnum[N_DIV]);
    end else begin : g_rest
      assign v_src    = sv[j-1];
      assign tag_src  = stag[j-1];
      assign rem_src  = srem[j-1];
      assign root_src = sroot[j-1];
      assign rad_src  = srad[j-1];
    end

    assign step = sqrt_step(rem_src, root_src, rad_src[RAD_WIDTH-1 -: 2]);

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j] <= 1'b0;
      end else if (adv) begin
        sv[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stag[j]  <= tag_src;
        srem[j]  <= step.rem;
        sroot[j] <= step.root;
        srad[j]  <= {rad_src[RAD_WIDTH-3:0], 2'b00};
      end
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (adv) begin
      mv <= sv[N_SQ-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mtag  <= stag[N_SQ-1];
      mprod <= PROD_WIDTH'(stag[N_SQ-1].speed) * PROD_WIDTH'(sroot[N_SQ-1]);
    end
  end

  // scale, saturate and select
  always_comb begin
    shifted     = mprod >> P_SHIFT;
    shifted_ext = CMP_WIDTH'(shifted);
    if (shifted_ext > CMP_WIDTH'(LIMIT_MAX)) begin
      sat = LIMIT_MAX;
    end else begin
      sat = shifted_ext[LIMIT_WIDTH-1:0];
    end
    cap_next.limit_valid      = mtag.lim;
    cap_next.speed_limit      = mtag.calc ? sat : '0;
    cap_next.merge_authorized = mtag.auth;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else if (adv) begin
      cap_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cap <= cap_next;
    end
  end

endmodule
